/* hdl/rcsp_pkg.sv */
// Shared types and constants for the chunk stream parser.
// Holds the per-stream slot record, result kinds and the header length table.
// No dependencies.
`timescale 1ns / 1ps

package rcsp_pkg;

    localparam logic [23:0] MASK24 = 24'hffffff;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] FMT_FULL  = 2'd0;
    localparam logic [1:0] FMT_DELTA = 2'd1;
    localparam logic [1:0] FMT_TIME  = 2'd2;
    localparam logic [1:0] FMT_CONT  = 2'd3;

    localparam logic [5:0] CSID_TWO_BYTE   = 6'd0;
    localparam logic [5:0] CSID_THREE_BYTE = 6'd1;

    localparam logic [7:0] TYPE_SET_CHUNK_SIZE = 8'd1;

    // Per chunk stream record, 153 bits.
    typedef struct packed {
        logic [23:0] length;
        logic [7:0]  mtype;
        logic [31:0] mstream;
        logic [31:0] tstamp;
        logic [31:0] delta;
        logic        ext;
        logic [23:0] owed;
    } slot_t;

    function automatic logic [4:0] header_len(input logic [1:0] fmt);
        case (fmt)
            FMT_FULL:  header_len = 5'd11;
            FMT_DELTA: header_len = 5'd7;
            FMT_TIME:  header_len = 5'd3;
            default:   header_len = 5'd0;
        endcase
    endfunction

endpackage

/* hdl/rcsp_slot_ram.sv */
// Stream table memory: one slot record per chunk stream, registered read.
// Depends on rcsp_pkg for slot_t. Entries never written read back as zero.
`timescale 1ns / 1ps

module rcsp_slot_ram
    import rcsp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output slot_t         rdata
);

    slot_t           mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    slot_t           rdata_reg;
    logic            rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* hdl/rtmp_chunk_stream_parser.sv */
// Chunk stream parser. Each completed basic header that names a stream in the table
// enters a load state while the stream table memory returns the slot record (one read
// port, registered read); no byte is accepted in that state. The slot of the
// current chunk stream is held in a working register and written back when the next
// basic header names a stream; a repeated stream id is forwarded from that register.
// A stream id at or above STREAM_SLOTS halts the parser with error results until
// reset. The stream table starts cleared through per-entry valid bits, no sweep.
// Depends on rcsp_pkg and rcsp_slot_ram.
`timescale 1ns / 1ps

module rtmp_chunk_stream_parser
    import rcsp_pkg::*;
#(
    parameter int STREAM_SLOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] stream_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [16:0] chunk_stream, [24:17] message_type, [48:25] message_length,
    // [80:49] message_stream, [112:81] time_stamp, [120:113] payload_byte, rest zero
    output logic [127:0] m_tdata,
    output logic [2:0]   m_tuser,   // [1:0] result_kind, [2] chunk_end
    output logic         m_tlast    // message_end
);

    localparam int AW = $clog2(STREAM_SLOTS);
    localparam logic [16:0] SLOTS17 = 17'(STREAM_SLOTS);

    localparam logic [2:0] PH_BASIC0  = 3'd0;
    localparam logic [2:0] PH_BASIC1  = 3'd1;
    localparam logic [2:0] PH_BASIC2A = 3'd2;
    localparam logic [2:0] PH_BASIC2B = 3'd3;
    localparam logic [2:0] PH_MSGHDR  = 3'd4;
    localparam logic [2:0] PH_EXTTS   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_LOAD    = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [16:0] cur_reg, cur_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [23:0] left_reg, left_next;
    logic [23:0] csize_reg, csize_next;
    logic [31:0] cap_reg, cap_next;
    logic        err_reg, err_next;
    logic        same_reg, same_next;
    slot_t       wk_reg, wk_next;
    logic        wkv_reg, wkv_next;

    logic         mval_reg;
    logic [127:0] mdata_reg;
    logic [2:0]   muser_reg;
    logic         mlast_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    slot_t         mem_rdata;

    logic         out_free, s_fire;
    logic         emit;
    logic [1:0]   e_kind;
    logic [7:0]   e_pb;
    logic         e_cend, e_mend, e_noslot;

    rcsp_slot_ram #(
        .DEPTH(STREAM_SLOTS),
        .AW   (AW)
    ) u_slot_ram (
        .aclk   (aclk),
        .aresetn(aresetn),
        .we     (mem_we),
        .waddr  (cur_reg[AW-1:0]),
        .wdata  (wk_reg),
        .re     (mem_re),
        .raddr  (mem_raddr),
        .rdata  (mem_rdata)
    );

    assign out_free = !mval_reg || m_tready;
    assign s_tready = out_free && (phase_reg != PH_LOAD);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        slot_t       s;
        logic [7:0]  b;
        logic [16:0] id;
        logic        id_done;
        logic        after_req, fin_req, hx, fresh;
        logic [31:0] ev;
        logic [4:0]  n;
        logic [23:0] t, csz, offset;
        logic [31:0] v;

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        cur_next   = cur_reg;
        fmt_next   = fmt_reg;
        left_next  = left_reg;
        csize_next = csize_reg;
        cap_next   = cap_reg;
        err_next   = err_reg;
        same_next  = same_reg;
        wkv_next   = wkv_reg;
        s          = wk_reg;
        b          = s_tdata;
        id         = '0;
        id_done    = 1'b0;
        after_req  = 1'b0;
        fin_req    = 1'b0;
        hx         = 1'b0;
        ev         = '0;
        fresh      = 1'b1;
        n          = cnt_reg;
        t          = '0;
        csz        = '0;
        offset     = '0;
        v          = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        emit       = 1'b0;
        e_kind     = KIND_HEADER;
        e_pb       = '0;
        e_cend     = 1'b0;
        e_mend     = 1'b0;
        e_noslot   = 1'b0;

        if (phase_reg == PH_LOAD) begin
            if (out_free) begin
                s         = same_reg ? wk_reg : mem_rdata;
                wkv_next  = 1'b1;
                cnt_next  = '0;
                acc_next  = '0;
                if (fmt_reg == FMT_CONT) begin
                    after_req = 1'b1;
                end else begin
                    phase_next = PH_MSGHDR;
                end
            end
        end else if (s_fire) begin
            if (err_reg) begin
                emit     = 1'b1;
                e_kind   = KIND_ERROR;
                e_noslot = 1'b1;
            end else begin
                case (phase_reg)
                    PH_BASIC0: begin
                        fmt_next = b[7:6];
                        if (b[5:0] == CSID_TWO_BYTE) begin
                            phase_next = PH_BASIC1;
                        end else if (b[5:0] == CSID_THREE_BYTE) begin
                            phase_next = PH_BASIC2A;
                        end else begin
                            id      = {11'd0, b[5:0]};
                            id_done = 1'b1;
                        end
                    end
                    PH_BASIC1: begin
                        id      = 17'd64 + {9'd0, b};
                        id_done = 1'b1;
                    end
                    PH_BASIC2A: begin
                        acc_next   = {24'd0, b};
                        phase_next = PH_BASIC2B;
                    end
                    PH_BASIC2B: begin
                        id      = 17'd64 + {9'd0, acc_reg[7:0]} + {1'b0, b, 8'd0};
                        id_done = 1'b1;
                    end
                    PH_MSGHDR: begin
                        if (n < 5'd3) begin
                            acc_next = {acc_reg[23:0], b};
                            if (n == 5'd2) begin
                                t     = acc_next[23:0];
                                s.ext = (t == MASK24);
                                if (fmt_reg == FMT_FULL) begin
                                    s.tstamp = {8'd0, t};
                                    s.delta  = '0;
                                end else begin
                                    s.delta = {8'd0, t};
                                end
                                acc_next = '0;
                            end
                        end else if (n < 5'd6) begin
                            acc_next = {acc_reg[23:0], b};
                            if (n == 5'd5) begin
                                s.length = acc_next[23:0];
                                acc_next = '0;
                            end
                        end else if (n == 5'd6) begin
                            s.mtype = b;
                        end else if (n < 5'd11) begin
                            // Message stream id arrives least significant byte first.
                            acc_next = acc_reg | ({24'd0, b} << {n - 5'd7, 3'b000});
                            if (n == 5'd10) begin
                                s.mstream = acc_next;
                            end
                        end
                        cnt_next = n + 5'd1;
                        if (cnt_next >= header_len(fmt_reg)) begin
                            after_req = 1'b1;
                        end
                    end
                    PH_EXTTS: begin
                        acc_next = {acc_reg[23:0], b};
                        cnt_next = n + 5'd1;
                        if (cnt_next >= 5'd4) begin
                            fin_req = 1'b1;
                            hx      = (fmt_reg != FMT_CONT);
                            ev      = acc_next;
                        end
                    end
                    PH_PAYLOAD: begin
                        offset = s.length - s.owed;
                        if (s.mtype == TYPE_SET_CHUNK_SIZE && offset < 24'd4) begin
                            cap_next = {cap_reg[23:0], b};
                        end
                        s.owed    = s.owed - 24'd1;
                        left_next = left_reg - 24'd1;
                        e_cend    = (left_next == '0);
                        e_mend    = (s.owed == '0);
                        if (e_mend && s.mtype == TYPE_SET_CHUNK_SIZE && s.length >= 24'd4) begin
                            v = cap_next;
                            if (v > {8'd0, MASK24}) begin
                                v = {8'd0, MASK24};
                            end
                            if (v == '0) begin
                                v = 32'd1;
                            end
                            csize_next = v[23:0];
                        end
                        if (e_cend) begin
                            phase_next = PH_BASIC0;
                        end
                        emit   = 1'b1;
                        e_kind = KIND_PAYLOAD;
                        e_pb   = b;
                    end
                    default: begin
                        phase_next = PH_BASIC0;
                    end
                endcase
            end
        end

        if (id_done) begin
            cur_next = id;
            if (id >= SLOTS17) begin
                err_next = 1'b1;
                emit     = 1'b1;
                e_kind   = KIND_ERROR;
                e_noslot = 1'b1;
            end else begin
                // Flush the working slot and fetch the named one.
                mem_we     = wkv_reg;
                mem_re     = 1'b1;
                mem_raddr  = id[AW-1:0];
                same_next  = wkv_reg && (cur_reg == id);
                phase_next = PH_LOAD;
            end
        end

        if (after_req) begin
            if (s.ext) begin
                phase_next = PH_EXTTS;
                cnt_next   = '0;
                acc_next   = '0;
            end else begin
                fin_req = 1'b1;
            end
        end

        if (fin_req) begin
            if (fmt_reg == FMT_FULL) begin
                if (hx) begin
                    s.tstamp = ev;
                end
            end else if (fmt_reg != FMT_CONT) begin
                if (hx) begin
                    s.delta = ev;
                end
                s.tstamp = s.tstamp + s.delta;
            end else if (s.owed == '0) begin
                s.tstamp = s.tstamp + s.delta;
            end else begin
                fresh = 1'b0;
            end
            if (fresh) begin
                s.owed   = s.length;
                cap_next = '0;
            end
            csz        = (csize_reg != '0) ? csize_reg : 24'd1;
            left_next  = (s.owed < csz) ? s.owed : csz;
            phase_next = (left_next != '0) ? PH_PAYLOAD : PH_BASIC0;
            emit       = 1'b1;
            e_kind     = KIND_HEADER;
            e_mend     = (s.owed == '0);
        end

        if (cfg_wr_en) begin
            csize_next = cfg_wr_data;
        end

        wk_next = s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BASIC0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            cur_reg   <= '0;
            fmt_reg   <= '0;
            left_reg  <= '0;
            csize_reg <= 24'd128;
            cap_reg   <= '0;
            err_reg   <= 1'b0;
            same_reg  <= 1'b0;
            wkv_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            cur_reg   <= cur_next;
            fmt_reg   <= fmt_next;
            left_reg  <= left_next;
            csize_reg <= csize_next;
            cap_reg   <= cap_next;
            err_reg   <= err_next;
            same_reg  <= same_next;
            wkv_reg   <= wkv_next;
            if (emit) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // Working slot and result payload carry no reset.
    always_ff @(posedge aclk) begin
        wk_reg <= wk_next;
        if (emit) begin
            if (e_noslot) begin
                mdata_reg <= {111'd0, cur_next};
            end else begin
                mdata_reg <= {7'd0, e_pb, wk_next.tstamp, wk_next.mstream,
                              wk_next.length, wk_next.mtype, cur_next};
            end
            muser_reg <= {e_cend, e_kind};
            mlast_reg <= e_mend;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

endmodule

/* dv/tb_top.sv */
// Self-checking bench for rtmp_chunk_stream_parser: well-formed chunk streams with random
// content, a byte-level predictor of the parser and an in-order result scoreboard.
// Depends on rcsp_pkg and the parser RTL.
`timescale 1ns / 1ps

import rcsp_pkg::*;

typedef enum logic [2:0] {
    PP_BASIC0, PP_BASIC1, PP_BASIC2A, PP_BASIC2B, PP_MSGHDR, PP_EXTTS, PP_PAYLOAD
} parse_phase_e;

typedef struct {
    logic [1:0]  kind;
    logic [16:0] cs;
    logic [7:0]  mtype;
    logic [23:0] mlen;
    logic [31:0] mstream;
    logic [31:0] tstamp;
    logic [7:0]  pbyte;
    logic        cend;
    logic        mend;
} parse_result_t;

class chunk_parser_board;
    slot_t         slots[64];
    parse_phase_e  phase;
    logic [4:0]    hdr_cnt;
    logic [31:0]   acc;
    logic [16:0]   cur_cs;
    logic [1:0]    cur_fmt;
    logic [23:0]   chunk_left;
    logic [23:0]   chunk_size;
    logic [31:0]   size_word;
    bit            halted;
    parse_result_t pending[$];
    int            n_in;
    int            n_bad;

    function void init();
        foreach (slots[i]) slots[i] = '0;
        phase = PP_BASIC0;
        hdr_cnt = 0;
        acc = 0;
        cur_cs = 0;
        cur_fmt = FMT_FULL;
        chunk_left = 0;
        chunk_size = 24'd128;
        size_word = 0;
        halted = 0;
        n_in = 0;
        n_bad = 0;
    endfunction

    function void write_size(logic [23:0] v);
        chunk_size = v;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] pb, logic ce, logic me);
        parse_result_t r;
        r.kind = kind;
        r.cs = cur_cs;
        if (kind == KIND_ERROR) begin
            r.mtype = 0; r.mlen = 0; r.mstream = 0; r.tstamp = 0;
        end else begin
            r.mtype = slots[cur_cs].mtype;
            r.mlen = slots[cur_cs].length;
            r.mstream = slots[cur_cs].mstream;
            r.tstamp = slots[cur_cs].tstamp;
        end
        r.pbyte = pb;
        r.cend = ce;
        r.mend = me;
        pending.insert(pending.size(), r);
    endfunction

    function void close_header(bit has_ext, logic [31:0] xv);
        bit fresh;
        logic [23:0] csz;
        fresh = 1;
        if (cur_fmt == FMT_FULL) begin
            if (has_ext) slots[cur_cs].tstamp = xv;
        end else if (cur_fmt != FMT_CONT) begin
            if (has_ext) slots[cur_cs].delta = xv;
            slots[cur_cs].tstamp += slots[cur_cs].delta;
        end else if (slots[cur_cs].owed == 0) begin
            slots[cur_cs].tstamp += slots[cur_cs].delta;
        end else begin
            fresh = 0;
        end
        if (fresh) begin
            slots[cur_cs].owed = slots[cur_cs].length;
            size_word = 0;
        end
        csz = (chunk_size != 0) ? chunk_size : 24'd1;
        chunk_left = (slots[cur_cs].owed < csz) ? slots[cur_cs].owed : csz;
        phase = (chunk_left != 0) ? PP_PAYLOAD : PP_BASIC0;
        push(KIND_HEADER, 8'd0, 1'b0, slots[cur_cs].owed == 0);
    endfunction

    function void fields_done();
        if (slots[cur_cs].ext) begin
            phase = PP_EXTTS;
            hdr_cnt = 0;
            acc = 0;
        end else begin
            close_header(0, 32'd0);
        end
    endfunction

    function void basic_done(logic [16:0] id);
        cur_cs = id;
        if (id >= 17'd64) begin
            halted = 1;
            push(KIND_ERROR, 8'd0, 1'b0, 1'b0);
        end else begin
            hdr_cnt = 0;
            acc = 0;
            if (cur_fmt == FMT_CONT) fields_done();
            else phase = PP_MSGHDR;
        end
    endfunction

    function void note_byte(logic [7:0] b);
        logic [23:0] offset;
        logic [31:0] v;
        logic        ce;
        logic        me;
        n_in++;
        if (halted) begin
            push(KIND_ERROR, 8'd0, 1'b0, 1'b0);
            return;
        end
        case (phase)
            PP_BASIC0: begin
                cur_fmt = b[7:6];
                if (b[5:0] == CSID_TWO_BYTE) phase = PP_BASIC1;
                else if (b[5:0] == CSID_THREE_BYTE) phase = PP_BASIC2A;
                else basic_done({11'd0, b[5:0]});
            end
            PP_BASIC1: basic_done(17'd64 + {9'd0, b});
            PP_BASIC2A: begin
                acc = {24'd0, b};
                phase = PP_BASIC2B;
            end
            PP_BASIC2B: basic_done(17'd64 + {9'd0, acc[7:0]} + {1'b0, b, 8'd0});
            PP_MSGHDR: begin
                if (hdr_cnt < 3) begin
                    acc = {acc[23:0], b};
                    if (hdr_cnt == 2) begin
                        slots[cur_cs].ext = (acc[23:0] == MASK24);
                        if (cur_fmt == FMT_FULL) begin
                            slots[cur_cs].tstamp = {8'd0, acc[23:0]};
                            slots[cur_cs].delta = 0;
                        end else begin
                            slots[cur_cs].delta = {8'd0, acc[23:0]};
                        end
                        acc = 0;
                    end
                end else if (hdr_cnt < 6) begin
                    acc = {acc[23:0], b};
                    if (hdr_cnt == 5) begin
                        slots[cur_cs].length = acc[23:0];
                        acc = 0;
                    end
                end else if (hdr_cnt == 6) begin
                    slots[cur_cs].mtype = b;
                end else if (hdr_cnt < 11) begin
                    acc = acc | ({24'd0, b} << (8 * (hdr_cnt - 7)));
                    if (hdr_cnt == 10) slots[cur_cs].mstream = acc;
                end
                hdr_cnt = hdr_cnt + 5'd1;
                if (hdr_cnt >= header_len(cur_fmt)) fields_done();
            end
            PP_EXTTS: begin
                acc = {acc[23:0], b};
                hdr_cnt = hdr_cnt + 5'd1;
                if (hdr_cnt >= 4) close_header(cur_fmt != FMT_CONT, acc);
            end
            default: begin
                offset = slots[cur_cs].length - slots[cur_cs].owed;
                if (slots[cur_cs].mtype == TYPE_SET_CHUNK_SIZE && offset < 4)
                    size_word = {size_word[23:0], b};
                slots[cur_cs].owed = slots[cur_cs].owed - 24'd1;
                chunk_left = chunk_left - 24'd1;
                ce = (chunk_left == 0);
                me = (slots[cur_cs].owed == 0);
                if (me && slots[cur_cs].mtype == TYPE_SET_CHUNK_SIZE
                        && slots[cur_cs].length >= 4) begin
                    v = size_word;
                    if (v > {8'd0, MASK24}) v = {8'd0, MASK24};
                    if (v == 0) v = 32'd1;
                    chunk_size = v[23:0];
                end
                if (ce) phase = PP_BASIC0;
                push(KIND_PAYLOAD, b, ce, me);
            end
        endcase
    endfunction

    function void check_result(logic [127:0] data, logic [2:0] user, logic last);
        parse_result_t got;
        parse_result_t want;
        got.kind = user[1:0];
        got.cs = data[16:0];
        got.mtype = data[24:17];
        got.mlen = data[48:25];
        got.mstream = data[80:49];
        got.tstamp = data[112:81];
        got.pbyte = data[120:113];
        got.cend = user[2];
        got.mend = last;
        if (pending.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected result transaction: %p", got);
            return;
        end
        want = pending[0];
        pending.delete(0);
        if (got.kind !== want.kind || got.cs !== want.cs || got.mtype !== want.mtype
                || got.mlen !== want.mlen || got.mstream !== want.mstream
                || got.tstamp !== want.tstamp || got.pbyte !== want.pbyte
                || got.cend !== want.cend || got.mend !== want.mend) begin
            n_bad++;
            if (n_bad <= 10) $display("result mismatch\n  expected %p\n  actual   %p", want, got);
        end
    endfunction
endclass

module tb_top;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [23:0]  cfg_wr_data = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    chunk_parser_board board = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;

    rtmp_chunk_stream_parser #(.STREAM_SLOTS(64)) dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The long hold-off is counted here so the sender keeps offering bytes meanwhile.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready = 0;
            hold_cycles--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_byte(logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = b;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        wait (board.pending.size() == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_chunk_size(logic [23:0] v);
        drain();
        cfg_wr_en = 1;
        cfg_wr_data = v;
        @(posedge aclk);
        board.write_size(v);
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    // One chunk: basic header, message header, extended timestamp when the stream
    // carries one, then as many payload bytes as the chunk holds.
    task automatic send_chunk(logic [5:0] cs, logic [1:0] fmt, logic [23:0] ts,
                              logic [23:0] mlen, logic [7:0] mtype, logic [31:0] xts,
                              logic [31:0] new_size);
        logic [23:0] offset;
        send_byte({fmt, cs});
        if (fmt != FMT_CONT) begin
            send_byte(ts[23:16]); send_byte(ts[15:8]); send_byte(ts[7:0]);
        end
        if (fmt == FMT_FULL || fmt == FMT_DELTA) begin
            send_byte(mlen[23:16]); send_byte(mlen[15:8]); send_byte(mlen[7:0]);
            send_byte(mtype);
        end
        if (fmt == FMT_FULL) repeat (4) send_byte(8'($urandom_range(0, 255)));
        if (board.phase == PP_EXTTS) begin
            send_byte(xts[31:24]); send_byte(xts[23:16]);
            send_byte(xts[15:8]); send_byte(xts[7:0]);
        end
        while (board.phase == PP_PAYLOAD) begin
            offset = board.slots[cs].length - board.slots[cs].owed;
            if (board.slots[cs].mtype == TYPE_SET_CHUNK_SIZE && offset < 4)
                send_byte(new_size[31 - 8 * offset -: 8]);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_chunk();
        logic [5:0]  cs;
        logic [1:0]  fmt;
        logic [23:0] ts;
        logic [23:0] mlen;
        logic [7:0]  mtype;
        logic [31:0] new_size;
        cs = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(2, 63))
                                         : 6'($urandom_range(2, 5));
        if (board.slots[cs].owed != 0 && $urandom_range(0, 4) != 0) fmt = FMT_CONT;
        else fmt = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0: ts = MASK24;
            1: ts = 24'($urandom_range(0, 15));
            default: ts = 24'($urandom_range(0, 24'hfffffe));
        endcase
        case ($urandom_range(0, 19))
            0, 1: mlen = 0;
            2: mlen = 24'($urandom_range(100, 300));
            default: mlen = 24'($urandom_range(1, 30));
        endcase
        mtype = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
            mtype = TYPE_SET_CHUNK_SIZE;
            mlen = $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 6)) : 24'd4;
        end
        case ($urandom_range(0, 9))
            0: new_size = 0;
            1: new_size = 32'hffffffff;
            2: new_size = {8'd0, MASK24};
            default: new_size = $urandom_range(1, 48);
        endcase
        send_chunk(cs, fmt, ts, mlen, mtype, $urandom, new_size);
    endtask

    initial begin
        int target;
        board.init();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        write_chunk_size(24'd3);

        // Directed: extremes of ids and timestamps, every format, empty message,
        // extended timestamps on fresh and continued chunks, set chunk size.
        send_chunk(6'd2, FMT_FULL, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
        send_chunk(6'd63, FMT_FULL, MASK24, 24'd7, 8'hff, 32'hffffffff, 32'd0);
        send_chunk(6'd63, FMT_CONT, 24'd0, 24'd0, 8'd0, 32'h12345678, 32'd0);
        send_chunk(6'd2, FMT_DELTA, 24'hfffffe, 24'd5, 8'd9, 32'd0, 32'd0);
        send_chunk(6'd2, FMT_TIME, MASK24, 24'd0, 8'd0, 32'h80000000, 32'd0);
        send_chunk(6'd63, FMT_CONT, 24'd0, 24'd0, 8'd0, 32'h0, 32'd0);
        send_chunk(6'd4, FMT_FULL, 24'd1, 24'd4, TYPE_SET_CHUNK_SIZE, 32'd0, 32'd0);
        send_chunk(6'd4, FMT_CONT, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
        send_chunk(6'd4, FMT_FULL, 24'd2, 24'd4, TYPE_SET_CHUNK_SIZE, 32'd0, 32'h01000000);
        send_chunk(6'd5, FMT_FULL, 24'd3, 24'd3, TYPE_SET_CHUNK_SIZE, 32'd0, 32'd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_chunk_size(24'd1); end
                1: begin idle_pct = 69; stall_pct = 0;  write_chunk_size(MASK24); end
                2: begin idle_pct = 0;  stall_pct = 69; write_chunk_size(24'd16); end
                default: begin idle_pct = 29; stall_pct = 29; write_chunk_size(24'd128); end
            endcase
            if (ph == 0) hold_cycles = 400;
            target = board.n_in + 440;
            while (board.n_in < target) begin
                random_chunk();
                if ($urandom_range(0, 49) == 0) drain();
            end
        end

        // Chunk stream id beyond the table halts the parser for good.
        drain();
        send_byte({FMT_FULL, CSID_TWO_BYTE});
        send_byte(8'd5);
        repeat (5) send_byte(8'($urandom_range(0, 255)));

        @(negedge aclk);
        s_tvalid = 0;
        wait (board.pending.size() == 0);
        repeat (20) @(posedge aclk);
        if (board.n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
